// ----- rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
// Package for the sorted priority queue: sizes, the entry and operation types,
// and the result status codes. No dependencies.
package spq_pkg;

	localparam int DEPTH = 64;
	localparam int DATA_WIDTH = 32;
	localparam int PRIO_WIDTH = 16;
	localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
	localparam int LIMIT_WIDTH = 7;
	localparam logic [LIMIT_WIDTH-1:0] RESET_LIMIT = LIMIT_WIDTH'(64);

	typedef enum logic [1:0] {
		ST_PUSHED = 2'd0,
		ST_FULL   = 2'd1,
		ST_POPPED = 2'd2,
		ST_EMPTY  = 2'd3
	} spq_status_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] value;
		logic signed [PRIO_WIDTH-1:0] prio;
	} spq_entry_t;

	// Operation broadcast to every cell of the chain.
	typedef struct packed {
		logic push;
		logic pop;
		spq_entry_t entry;
	} spq_op_t;

endpackage

// ----- rtl/spq_cell.sv -----
`timescale 1ns / 1ps
// One cell of the sorted chain: holds one entry and its valid bit.
// Depends on spq_pkg.
module spq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  spq_pkg::spq_op_t  op,
	input  logic              left_keep,
	input  spq_pkg::spq_entry_t left_entry,
	input  logic              left_valid,
	input  spq_pkg::spq_entry_t right_entry,
	input  logic              right_valid,
	output spq_pkg::spq_entry_t entry,
	output logic              valid,
	output logic              keep
);

	spq_pkg::spq_entry_t entry_q;
	logic valid_q;

	// A cell keeps its entry on a push when its priority is at least the new
	// one, which puts equal priorities in arrival order.
	assign keep = valid_q && ($signed(entry_q.prio) >= $signed(op.entry.prio));
	assign entry = entry_q;
	assign valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (op.push) begin
			if (!keep) begin
				valid_q <= left_keep ? 1'b1 : left_valid;
			end
		end else if (op.pop) begin
			valid_q <= right_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (op.push) begin
			if (!keep) begin
				entry_q <= left_keep ? op.entry : left_entry;
			end
		end else if (op.pop) begin
			entry_q <= right_entry;
		end
	end

endmodule

// ----- rtl/sorted_priority_queue_core.sv -----
`timescale 1ns / 1ps
// Top level of the sorted priority queue: a chain of spq_cell instances,
// the entry count, the capacity register and the result register. Uses spq_pkg.
//
// Usage: an item transfers on the input channel when in_valid is high and
// in_stall is low. mode 0 pushes (in_value, in_priority); mode 1 pops the
// head. Every item gives one result on the output channel, which transfers
// when out_valid is high and out_stall is low: status, the popped entry
// (zero for pushes and empty pops) and entry_total after the item.
// The result is registered and appears in the cycle after the input
// transfer. Throughput is one item per cycle while in_stall is low; all
// cells compare the new priority against their own in parallel and shift
// by one place, so the chain completes any push or pop as the item transfers.
// While a result waits under out_stall, in_stall is raised; a waiting
// result is replaced in the same cycle that it is taken.
// The capacity register is written through cfg_valid/cfg_data (cfg_ready is
// always high); the user must write it only while the queue is idle, as the
// block does not enforce this. Values above the depth act as the depth. Reset
// empties the queue, sets the capacity to 64 and drops any pending result.
module sorted_priority_queue_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [spq_pkg::LIMIT_WIDTH-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 mode,
	input  logic [spq_pkg::DATA_WIDTH-1:0]       in_value,
	input  logic signed [spq_pkg::PRIO_WIDTH-1:0] in_priority,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           status,
	output logic [spq_pkg::DATA_WIDTH-1:0]       out_value,
	output logic signed [spq_pkg::PRIO_WIDTH-1:0] out_priority,
	output logic [spq_pkg::COUNT_WIDTH-1:0]      entry_total
);

	localparam int D = spq_pkg::DEPTH;
	localparam int CW = spq_pkg::COUNT_WIDTH;
	localparam int LW = spq_pkg::LIMIT_WIDTH;

	logic [LW-1:0] cap_q;
	logic [CW-1:0] count_q;
	logic out_valid_q;
	spq_pkg::spq_status_t status_q;
	logic [spq_pkg::DATA_WIDTH-1:0] value_q;
	logic signed [spq_pkg::PRIO_WIDTH-1:0] prio_q;
	logic [CW-1:0] total_q;

	logic accept;
	logic full;
	logic empty;
	logic [CW:0] limit;
	spq_pkg::spq_op_t op;
	spq_pkg::spq_status_t status_d;
	logic [CW-1:0] count_d;

	spq_pkg::spq_entry_t cell_entry [D];
	logic cell_valid [D];
	logic cell_keep [D];

	assign cfg_ready = 1'b1;
	assign in_stall = out_valid_q && out_stall;
	assign accept = in_valid && !in_stall;

	// Limits above the depth act as the depth.
	assign limit = ((CW + 1)'(cap_q) > (CW + 1)'(D)) ? (CW + 1)'(D) : (CW + 1)'(cap_q);
	assign full = {1'b0, count_q} >= limit;
	assign empty = count_q == '0;

	always_comb begin
		op.push = accept && !mode && !full;
		op.pop = accept && mode && !empty;
		op.entry.value = in_value;
		op.entry.prio = in_priority;
		count_d = count_q;
		if (!mode) begin
			status_d = full ? spq_pkg::ST_FULL : spq_pkg::ST_PUSHED;
			if (!full) begin
				count_d = count_q + CW'(1);
			end
		end else begin
			status_d = empty ? spq_pkg::ST_EMPTY : spq_pkg::ST_POPPED;
			if (!empty) begin
				count_d = count_q - CW'(1);
			end
		end
	end

	genvar i;
	generate
		for (i = 0; i < D; i++) begin : g_cell
			spq_pkg::spq_entry_t left_entry;
			spq_pkg::spq_entry_t right_entry;
			logic left_valid;
			logic left_keep;
			logic right_valid;

			if (i == 0) begin : g_head
				// The head has nothing to its left: the new entry enters here
				// when the head itself does not keep its place.
				assign left_entry = op.entry;
				assign left_valid = 1'b0;
				assign left_keep = 1'b1;
			end else begin : g_mid
				assign left_entry = cell_entry[i-1];
				assign left_valid = cell_valid[i-1];
				assign left_keep = cell_keep[i-1];
			end

			if (i == D - 1) begin : g_tail
				assign right_entry = cell_entry[i];
				assign right_valid = 1'b0;
			end else begin : g_body
				assign right_entry = cell_entry[i+1];
				assign right_valid = cell_valid[i+1];
			end

			spq_cell u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.op          (op),
				.left_keep   (left_keep),
				.left_entry  (left_entry),
				.left_valid  (left_valid),
				.right_entry (right_entry),
				.right_valid (right_valid),
				.entry       (cell_entry[i]),
				.valid       (cell_valid[i]),
				.keep        (cell_keep[i])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= spq_pkg::RESET_LIMIT;
			count_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (accept) begin
				count_q <= count_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_d;
			total_q <= count_d;
			if (mode && !empty) begin
				value_q <= cell_entry[0].value;
				prio_q <= cell_entry[0].prio;
			end else begin
				value_q <= '0;
				prio_q <= '0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign out_value = value_q;
	assign out_priority = prio_q;
	assign entry_total = total_q;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for sorted_priority_queue_core: random push/pop traffic
// against a sorted-list predictor. Depends on spq_pkg and the core RTL.
module tb;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP = 1'b1;
	localparam int CYCLE_LIMIT = 300000;
	localparam int DW = spq_pkg::DATA_WIDTH;
	localparam int PW = spq_pkg::PRIO_WIDTH;
	localparam int CW = spq_pkg::COUNT_WIDTH;
	localparam int LW = spq_pkg::LIMIT_WIDTH;
	localparam int D = spq_pkg::DEPTH;

	typedef struct {
		logic op;
		logic [DW-1:0] val;
		logic signed [PW-1:0] pri;
	} queue_op_t;

	typedef struct {
		spq_pkg::spq_status_t st;
		logic [DW-1:0] val;
		logic signed [PW-1:0] pri;
		logic [CW-1:0] total;
	} queue_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [LW-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic mode = OP_PUSH;
	logic [DW-1:0] in_value = '0;
	logic signed [PW-1:0] in_priority = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] status;
	logic [DW-1:0] out_value;
	logic signed [PW-1:0] out_priority;
	logic [CW-1:0] entry_total;

	// Predictor state: entries kept in service order.
	logic [DW-1:0] held_val [D];
	logic signed [PW-1:0] held_pri [D];
	int held_count = 0;
	logic [LW-1:0] limit_reg = spq_pkg::RESET_LIMIT;

	queue_op_t pending_ops[$];
	queue_result_t expected_results[$];
	bit in_took = 1'b0;
	bit cfg_took = 1'b0;
	bit send_quiet = 1'b0;
	bit recv_quiet = 1'b0;
	int send_gap = 0;
	int stall_left = 0;
	int hold_left = 0;
	int errors = 0;
	int cycles = 0;
	int n_pushed = 0, n_refused = 0, n_popped = 0, n_empty = 0;

	sorted_priority_queue_core DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.in_value(in_value),
		.in_priority(in_priority),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.out_value(out_value),
		.out_priority(out_priority),
		.entry_total(entry_total)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_gap(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Applies one push or pop to the held list and returns the result it yields.
	function automatic queue_result_t queue_apply(logic op, logic [DW-1:0] v,
			logic signed [PW-1:0] p);
		queue_result_t r;
		int eff_limit;
		int pos;
		int k;
		r.st = spq_pkg::ST_PUSHED;
		r.val = '0;
		r.pri = '0;
		eff_limit = (limit_reg > D) ? D : int'(limit_reg);
		if (op == OP_PUSH) begin
			if (held_count >= eff_limit) begin
				r.st = spq_pkg::ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_count && held_pri[pos] >= p)
					pos++;
				for (k = held_count; k > pos; k--) begin
					held_val[k] = held_val[k-1];
					held_pri[k] = held_pri[k-1];
				end
				held_val[pos] = v;
				held_pri[pos] = p;
				held_count++;
			end
		end else if (held_count == 0) begin
			r.st = spq_pkg::ST_EMPTY;
		end else begin
			r.st = spq_pkg::ST_POPPED;
			r.val = held_val[0];
			r.pri = held_pri[0];
			for (k = 1; k < held_count; k++) begin
				held_val[k-1] = held_val[k];
				held_pri[k-1] = held_pri[k];
			end
			held_count--;
		end
		r.total = CW'(held_count);
		return r;
	endfunction

	task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
		if (errors < 40)
			$display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want, got);
		errors++;
	endtask

	// Sender: a new item is offered only after the previous one has transferred.
	always @(negedge clk) begin
		queue_op_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_took) begin
			if (send_gap > 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (pending_ops.size() > 0) begin
				it = pending_ops.pop_front();
				mode <= it.op;
				in_value <= it.val;
				in_priority <= it.pri;
				in_valid <= 1'b1;
				send_gap = pick_gap(send_quiet);
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: a long hold-off when requested, random short and long stalls otherwise.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_gap(recv_quiet);
		end
	end

	// Monitor: results are checked before the prediction for a new transfer is queued.
	always @(posedge clk) begin
		queue_result_t want;
		queue_result_t pred;
		if (!arst_n) begin
			in_took = 1'b0;
			cfg_took = 1'b0;
		end else begin
			cfg_took = cfg_valid && cfg_ready;
			if (cfg_took)
				limit_reg = cfg_data;
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					if (errors < 40)
						$display("%0t: unexpected result: status %0d, total %0d",
							$time, status, entry_total);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.st)
						report_mismatch("status", want.st, status);
					if (out_value !== want.val)
						report_mismatch("out_value", want.val, out_value);
					if (out_priority !== want.pri)
						report_mismatch("out_priority", 16'(want.pri), 16'(out_priority));
					if (entry_total !== want.total)
						report_mismatch("entry_total", want.total, entry_total);
				end
			end
			in_took = in_valid && !in_stall;
			if (in_took) begin
				pred = queue_apply(mode, in_value, in_priority);
				case (pred.st)
					spq_pkg::ST_PUSHED: n_pushed++;
					spq_pkg::ST_FULL: n_refused++;
					spq_pkg::ST_POPPED: n_popped++;
					default: n_empty++;
				endcase
				expected_results.push_back(pred);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
			$display("** sorted_priority_queue_core: FAILED **");
			$finish;
		end
	end

	task automatic add_op(logic op, logic [DW-1:0] v, logic signed [PW-1:0] p);
		queue_op_t it;
		it.op = op;
		it.val = v;
		it.pri = p;
		pending_ops.push_back(it);
	endtask

	// Waits until every item has transferred and every result has arrived.
	// The check runs just after the falling edge, once the sender has settled.
	task automatic wait_drained();
		do begin
			@(negedge clk);
			#1;
		end while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (3) @(negedge clk);
	endtask

	task automatic set_limit(logic [LW-1:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		while (!cfg_took)
			@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data <= LW'($urandom);
	endtask

	task automatic run_phase(logic [LW-1:0] lim, int push_pct, int n, bit ties,
			bit quiet, int hold);
		logic signed [PW-1:0] p;
		int i;
		set_limit(lim);
		send_quiet = quiet;
		recv_quiet = quiet;
		if (hold > 0) begin
			@(posedge clk);
			hold_left = hold;
		end
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 15) == 0)
				p = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
			else if (ties)
				p = PW'($urandom_range(0, 6)) - PW'(3);
			else
				p = PW'($urandom);
			add_op(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP, $urandom, p);
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Extremes, equal priorities leaving in arrival order, and pops past empty.
		add_op(OP_POP, 32'h1234_5678, 16'sh0001);
		add_op(OP_PUSH, 32'h0000_0000, 16'sh8000);
		add_op(OP_PUSH, 32'hffff_ffff, 16'sh7fff);
		add_op(OP_PUSH, 32'ha5a5_a5a5, 16'sh0000);
		add_op(OP_PUSH, 32'h5a5a_5a5a, 16'shffff);
		add_op(OP_PUSH, 32'h0000_0001, 16'sh0000);
		add_op(OP_PUSH, 32'h0000_0002, 16'sh0000);
		add_op(OP_PUSH, 32'h0000_0003, 16'sh7fff);
		repeat (8) add_op(OP_POP, 32'hdead_beef, 16'sh8000);

		// A zero limit refuses every push; the pop finds the queue empty.
		set_limit(LW'(0));
		add_op(OP_PUSH, 32'h0bad_f00d, 16'sh0010);
		add_op(OP_POP, 32'h0, 16'sh0);

		set_limit(LW'(2));
		add_op(OP_PUSH, 32'h0000_0011, 16'sh0005);
		add_op(OP_PUSH, 32'h0000_0022, 16'sh0009);
		add_op(OP_PUSH, 32'h0000_0033, 16'sh0007);

		// Limit lowered below the count: entries stay, pushes are refused.
		set_limit(LW'(1));
		add_op(OP_PUSH, 32'h0000_0044, 16'sh0001);
		add_op(OP_POP, 32'h0, 16'sh0);
		add_op(OP_PUSH, 32'h0000_0055, 16'sh0002);
		add_op(OP_POP, 32'h0, 16'sh0);
		add_op(OP_POP, 32'h0, 16'sh0);

		run_phase(LW'(64), 55, 60, 1'b0, 1'b0, 0);
		// Limit above the depth acts as the depth: fill and push past it.
		run_phase(LW'(127), 85, 90, 1'b0, 1'b0, 0);
		run_phase(LW'(127), 20, 50, 1'b1, 1'b0, 0);
		run_phase(LW'(0), 50, 20, 1'b0, 1'b0, 0);
		run_phase(LW'(64), 100, 30, 1'b1, 1'b1, 0);
		run_phase(LW'(3), 50, 40, 1'b1, 1'b0, 0);
		run_phase(LW'(1), 50, 30, 1'b0, 1'b0, 0);
		// Receiver holds off while the sender keeps offering back to back.
		run_phase(LW'(64), 70, 100, 1'b1, 1'b1, 60);
		run_phase(LW'(64), 40, 40, 1'b1, 1'b0, 0);

		wait_drained();
		repeat (5) @(posedge clk);
		if (expected_results.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, expected_results.size());
			errors++;
		end
		$display("Covered %0d pushes, %0d refused pushes, %0d pops and %0d empty pops",
			n_pushed, n_refused, n_popped, n_empty);
		$display("over capacity settings 0, 1, 2, 3, 64 and 127; %0d mismatches.", errors);
		if (errors == 0)
			$display("** sorted_priority_queue_core: PASSED **");
		else
			$display("** sorted_priority_queue_core: FAILED **");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue_core.sv
sim/tb.sv
